// File: sv/stlb_pkg.sv
// Shared types and constants for the sorted-table lower-bound search block.
// No dependencies; imported by stlb_search and the top level.
`timescale 1ns / 1ps
`default_nettype none

package stlb_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_W   = PADDR_W - 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ENTRIES_IN_USE = REG_IDX_W'(0);

    // operation codes on the input channel
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_DONE
    } search_state_t;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic [DATA_W-1:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
    } mem_rd_t;

endpackage

`default_nettype wire

// File: sv/stlb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stlb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/stlb_search.sv
// Input handshake, table loads and the binary-search sequencer with its result register.
// Depends on stlb_pkg; drives the table RAM through mem_wr_t / mem_rd_t.
`timescale 1ns / 1ps
`default_nettype none

module stlb_search import stlb_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [POS_W-1:0]         entries_in_use,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_func,
    input  wire logic [ADDR_W-1:0]        s_slot,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [POS_W-1:0]              m_position,
    output logic                          m_found,
    output mem_wr_t                       mem_wr,
    output mem_rd_t                       mem_rd,
    input  wire logic [DATA_W-1:0]        rd_data
);

    search_state_t              state_reg, state_next;
    logic [POS_W-1:0]           lo_reg, lo_next;
    logic [POS_W-1:0]           hi_reg, hi_next;
    logic [ADDR_W-1:0]          mid_reg, mid_next;
    logic signed [DATA_W-1:0]   key_reg, key_next;
    logic [POS_W-1:0]           count_reg, count_next;
    logic                       m_valid_reg, m_valid_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       found_reg, found_next;

    logic                       step_less;
    logic [POS_W-1:0]           step_lo;
    logic [POS_W-1:0]           step_hi;
    logic [POS_W:0]             step_sum;
    logic [ADDR_W-1:0]          step_mid;
    logic [POS_W-1:0]           count_sat;

    // one halving step on the entry read in the previous cycle
    assign step_less = $signed(rd_data) < key_reg;
    assign step_lo   = step_less ? (POS_W'(mid_reg) + POS_W'(1)) : lo_reg;
    assign step_hi   = step_less ? hi_reg : POS_W'(mid_reg);
    assign step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
    assign step_mid  = step_sum[ADDR_W:1];

    assign count_sat = (entries_in_use > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                                : entries_in_use;

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pos_next     = pos_reg;
        found_next   = found_reg;
        s_ready      = 1'b0;
        mem_wr       = '0;
        mem_rd       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_LOAD) begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = s_slot;
                        mem_wr.data = s_value;
                    end else begin
                        key_next   = s_value;
                        count_next = count_sat;
                        lo_next    = '0;
                        hi_next    = count_sat;
                        state_next = (count_sat == '0) ? ST_DONE : ST_START;
                    end
                end
            end
            ST_START: begin
                // lo is zero here, so the first midpoint is hi / 2
                mid_next    = hi_reg[POS_W-1:1];
                mem_rd.en   = 1'b1;
                mem_rd.addr = hi_reg[POS_W-1:1];
                state_next  = ST_SEARCH;
            end
            ST_SEARCH: begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi) begin
                    mid_next    = step_mid;
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = step_mid;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free or drains this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    pos_next     = lo_reg;
                    found_next   = lo_reg < count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        count_reg <= count_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_position = pos_reg;
    assign m_found    = found_reg;

endmodule

`default_nettype wire

// File: sv/sorted_table_lower_bound_top.sv
// Top level of the sorted-table lower-bound search: APB register, table RAM, sequencer.
// Depends on stlb_pkg, stlb_ram and stlb_search.
//
// A load item (func 0) writes one signed 32-bit entry into the 1024-entry table;
// it gives no result. A query item (func 1) runs a binary search over the first
// entries_in_use entries (saturated at 1024) and returns the lower bound with a
// found flag. A query steps through accept, issue of the first table read, one
// halving step per compare, and the load of the result register; when the count is
// zero it goes from accept straight to the result load. The result register
// load waits while an earlier result is still held on the m_ channel. In the
// halving loop, fed by the registered read data of the table RAM, each step
// compares the entry just read and issues the next read in the same cycle. Items are
// handled one at a time; the next item is accepted while a finished result still
// waits on the m_ channel. The table needs no clearing after reset; reading an entry
// never loaded gives an undefined result.
// entries_in_use sits at byte address 0 and should only change while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_lower_bound_top import stlb_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_W-1:0]       paddr,
    input  wire logic [PDATA_W-1:0]       pwdata,
    output logic      [PDATA_W-1:0]       prdata,
    output logic                          pready,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_func,
    input  wire logic [ADDR_W-1:0]        s_slot,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [POS_W-1:0]              m_position,
    output logic                          m_found
);

    logic [POS_W-1:0]  entries_in_use_reg, entries_in_use_next;
    logic              reg_hit;
    mem_wr_t           mem_wr;
    mem_rd_t           mem_rd;
    logic [DATA_W-1:0] rd_data;

    assign pready  = 1'b1;
    assign reg_hit = paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE;

    always_comb begin
        entries_in_use_next = entries_in_use_reg;
        if (psel && penable && pwrite && reg_hit) begin
            entries_in_use_next = pwdata[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= '0;
        end else begin
            entries_in_use_reg <= entries_in_use_next;
        end
    end

    assign prdata = reg_hit ? PDATA_W'(entries_in_use_reg) : '0;

    stlb_search u_search (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entries_in_use (entries_in_use_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot         (s_slot),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_position     (m_position),
        .m_found        (m_found),
        .mem_wr         (mem_wr),
        .mem_rd         (mem_rd),
        .rd_data        (rd_data)
    );

    stlb_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_wr.en),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .re    (mem_rd.en),
        .raddr (mem_rd.addr),
        .rdata (rd_data)
    );

`ifndef SYNTHESIS
    // a found hit always points inside the table
    a_found_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_position[POS_W-1])
        else $error("found result points past the table");

    // a query transfer starts a search, so input stalls the next cycle
    a_query_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == FUNC_QUERY) |=> !s_ready)
        else $error("input accepted while a search is running");

    // loads and search reads never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_rd.en |-> !mem_wr.en)
        else $error("table read and write in the same cycle");
`endif

endmodule

`default_nettype wire
